>>> sv/mexp_pkg.sv
// Shared constants and types for the modular exponentiation core.
// No dependencies; compiled first.
package mexp_pkg;

    localparam int FIELD_W = 32;
    localparam int WIDTH   = 32;
    localparam int CNT_W   = $clog2(WIDTH);

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_SQUARE = 5'b00100,
        S_MULT   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_SQUARE,
        OP_MULT
    } t_op;

    typedef struct packed {
        logic load;
        logic step;
        t_op  op;
        logic start_mul;
        logic write_base;
        logic write_acc;
        logic exp_shift;
        logic write_result;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_msb;
    } t_dp_status;

endpackage

>>> sv/mexp_in_if.sv
// Input channel: one word carries base, exponent and modulus.
// Depends on mexp_pkg.
interface mexp_in_if import mexp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field base;
    t_field exponent;
    t_field modulus;

    modport source (output valid, base, exponent, modulus, input ready);
    modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

>>> sv/mexp_out_if.sv
// Output channel: one word carries the result.
// Depends on mexp_pkg.
interface mexp_out_if import mexp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

>>> sv/mexp_datapath.sv
// Datapath: operand registers and one shift-add modular step unit.
// Driven by mexp_ctrl through t_dp_cmd; depends on mexp_pkg.
module mexp_datapath import mexp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_field     i_base,
    input  t_field     i_exponent,
    input  t_field     i_modulus,
    output t_dp_status o_status,
    output t_field     o_result
);

    t_word  r_mod;
    t_word  r_exp;
    t_word  r_base;
    t_word  r_acc;
    t_word  r_prod;
    t_word  r_bsh;
    logic   r_exp_zero;
    t_field r_result;

    logic             w_bit;
    t_word            w_addend;
    logic [WIDTH+1:0] w_sum;
    logic [WIDTH+1:0] w_mod1;
    logic [WIDTH+1:0] w_mod2;
    logic [WIDTH+1:0] w_sub1;
    logic [WIDTH+1:0] w_sub2;
    t_word            w_step;
    t_word            w_acc_next;

    assign w_bit = r_bsh[WIDTH-1];

    always_comb begin
        case (i_cmd.op)
            OP_REDUCE: w_addend = {{(WIDTH-1){1'b0}}, w_bit};
            OP_SQUARE: w_addend = w_bit ? r_acc : '0;
            OP_MULT:   w_addend = w_bit ? r_base : '0;
            default:   w_addend = '0;
        endcase
    end

    // 2*prod + addend < 3*mod: subtract 0, mod or 2*mod
    assign w_sum  = {1'b0, r_prod, 1'b0} + {2'b00, w_addend};
    assign w_mod1 = {2'b00, r_mod};
    assign w_mod2 = {1'b0, r_mod, 1'b0};
    assign w_sub1 = w_sum - w_mod1;
    assign w_sub2 = w_sum - w_mod2;

    always_comb begin
        if (w_sum >= w_mod2) begin
            w_step = w_sub2[WIDTH-1:0];
        end else if (w_sum >= w_mod1) begin
            w_step = w_sub1[WIDTH-1:0];
        end else begin
            w_step = w_sum[WIDTH-1:0];
        end
    end

    assign w_acc_next = i_cmd.write_acc ? w_step : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod      <= WIDTH'(i_modulus);
            r_exp      <= WIDTH'(i_exponent);
            r_bsh      <= WIDTH'(i_base);
            r_prod     <= '0;
            r_acc      <= (WIDTH'(i_modulus) == WIDTH'(1)) ? '0 : WIDTH'(1);
            r_exp_zero <= (WIDTH'(i_exponent) == '0);
        end else begin
            if (i_cmd.start_mul) begin
                r_prod <= '0;
                r_bsh  <= w_acc_next;
            end else if (i_cmd.step) begin
                r_prod <= w_step;
                r_bsh  <= {r_bsh[WIDTH-2:0], 1'b0};
            end
            if (i_cmd.write_base) begin
                r_base <= w_step;
            end
            if (i_cmd.write_acc) begin
                r_acc <= w_step;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= {r_exp[WIDTH-2:0], 1'b0};
            end
        end
        if (i_cmd.write_result) begin
            r_result <= r_exp_zero ? FIELD_W'(1) : FIELD_W'(r_acc);
        end
    end

    assign o_status.exp_zero = r_exp_zero;
    assign o_status.exp_msb  = r_exp[WIDTH-1];
    assign o_result          = r_result;

    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load && r_mod != '0) |=> (r_prod < r_mod))
        else $error("partial product not below modulus");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start_mul && !i_cmd.load) |=> (r_prod == '0))
        else $error("product not cleared at multiply start");

endmodule

>>> sv/mexp_ctrl.sv
// Controller: sequences base reduction, squarings and multiplies per exponent bit.
// Drives mexp_datapath through t_dp_cmd; depends on mexp_pkg.
module mexp_ctrl import mexp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    t_cnt   r_ecnt, n_ecnt;
    logic   r_out_valid, n_out_valid;

    logic w_cnt_last;
    logic w_ecnt_last;

    assign w_cnt_last  = (r_cnt == CNT_W'(WIDTH - 1));
    assign w_ecnt_last = (r_ecnt == CNT_W'(WIDTH - 1));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ecnt     = r_ecnt;
        o_cmd      = '0;
        o_cmd.op   = OP_REDUCE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.exp_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                    o_cmd.op   = OP_REDUCE;
                    n_cnt      = w_cnt_last ? '0 : r_cnt + CNT_W'(1);
                    if (w_cnt_last) begin
                        o_cmd.write_base = 1'b1;
                        o_cmd.start_mul  = 1'b1;
                        n_ecnt           = '0;
                        n_state          = S_SQUARE;
                    end
                end
            end
            S_SQUARE: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_SQUARE;
                n_cnt      = w_cnt_last ? '0 : r_cnt + CNT_W'(1);
                if (w_cnt_last) begin
                    o_cmd.write_acc = 1'b1;
                    if (i_status.exp_msb) begin
                        o_cmd.start_mul = 1'b1;
                        n_state         = S_MULT;
                    end else begin
                        o_cmd.exp_shift = 1'b1;
                        if (w_ecnt_last) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.start_mul = 1'b1;
                            n_ecnt          = r_ecnt + CNT_W'(1);
                        end
                    end
                end
            end
            S_MULT: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_MULT;
                n_cnt      = w_cnt_last ? '0 : r_cnt + CNT_W'(1);
                if (w_cnt_last) begin
                    o_cmd.write_acc = 1'b1;
                    o_cmd.exp_shift = 1'b1;
                    if (w_ecnt_last) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.start_mul = 1'b1;
                        n_ecnt          = r_ecnt + CNT_W'(1);
                        n_state         = S_SQUARE;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.write_result = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.write_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ecnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ecnt      <= n_ecnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write_result |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_REDUCE && r_cnt == '0))
        else $error("accepted word did not start reduction");

    a_mult_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULT && !w_cnt_last) |=>
            (r_state == S_MULT && r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("multiply step count broken");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write_result |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after finish");

endmodule

>>> sv/modular_exponentiation_core.sv
// Modular exponentiation core: base^exponent mod modulus, square-and-multiply.
// Instantiates mexp_ctrl and mexp_datapath; depends on mexp_pkg, mexp_in_if, mexp_out_if.
//
//  channel  dir  word fields                    handshake
//  i_in     in   base, exponent, modulus (32b)  valid/ready
//  o_out    out  result (32b)                   valid/ready
//
// One word at a time. A zero exponent goes straight to the finish state;
// otherwise the base is reduced, then each exponent bit takes a squaring
// and, for a one bit, a multiply, on the one-bit-per-cycle shift-add modular
// multiplier. The result sits in an output register, so a new word is taken
// while it waits. Synchronous active-low reset clears the controller only.
module modular_exponentiation_core import mexp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;
    t_field     w_result;

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mexp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_base     (i_in.base),
        .i_exponent (i_in.exponent),
        .i_modulus  (i_in.modulus),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    assign i_in.ready   = w_in_ready;
    assign o_out.valid  = w_out_valid;
    assign o_out.result = w_result;

endmodule
